// ===== hw/rtl/sdsm_pkg.sv =====
// ----------------------------------------------------------------------------
// sdsm_pkg
// shared types and constants for the stepper driver spi datagram master
// ----------------------------------------------------------------------------
package sdsm_pkg;

  localparam int unsigned FrameBits = 40;
  localparam int unsigned CsBits = 5;

  // address byte flag for a register write
  localparam logic WriteFlag = 1'b1;
  // reset value of the half period register
  localparam logic [7:0] HalfPeriodReset = 8'd10;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOW  = 4'b0010,
    ST_HIGH = 4'b0100,
    ST_GAP  = 4'b1000
  } seq_state_e;

  typedef enum logic {
    MODE_READ  = 1'b0,
    MODE_WRITE = 1'b1
  } xfer_mode_e;

  typedef struct packed {
    logic          start_req;
    logic          mode;
    logic [2:0]    axis;
    logic [6:0]    register_address;
    logic [31:0]   write_data;
    logic          miso_level;
  } req_t;

  typedef struct packed {
    logic          sck_level;
    logic          mosi_level;
    logic [4:0]    chip_select_n;
    logic          busy_res;
    logic          done_res;
    logic [7:0]    status_byte;
    logic [31:0]   read_data;
  } res_t;

endpackage

// ===== hw/rtl/sdsm_if.sv =====
// ----------------------------------------------------------------------------
// sdsm_if
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface sdsm_req_if;
  logic        valid;
  logic        ready;
  logic        start_req;
  logic        mode;
  logic [2:0]  axis;
  logic [6:0]  register_address;
  logic [31:0] write_data;
  logic        miso_level;

  modport source (
    output valid, start_req, mode, axis, register_address, write_data, miso_level,
    input  ready
  );
  modport sink (
    input  valid, start_req, mode, axis, register_address, write_data, miso_level,
    output ready
  );
endinterface

interface sdsm_res_if;
  logic        valid;
  logic        ready;
  logic        sck_level;
  logic        mosi_level;
  logic [4:0]  chip_select_n;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  status_byte;
  logic [31:0] read_data;

  modport source (
    output valid, sck_level, mosi_level, chip_select_n, busy_res, done_res,
           status_byte, read_data,
    input  ready
  );
  modport sink (
    input  valid, sck_level, mosi_level, chip_select_n, busy_res, done_res,
           status_byte, read_data,
    output ready
  );
endinterface

// ===== hw/rtl/stepper_driver_spi_datagram_master.sv =====
// ----------------------------------------------------------------------------
// stepper_driver_spi_datagram_master
// mode 3 spi master for 40-bit stepper driver datagrams, one tick per request
// ----------------------------------------------------------------------------
// Every request on req_i is one tick of the serial engine and yields exactly
// one result on res_o carrying the pin levels after that tick (sck, mosi,
// active-low chip selects), busy, a one-tick done flag and, on done, the
// status byte and 32 read bits. One request is taken per clock cycle: the
// sequencer state is updated by a single pass of logic and the result lands
// in a one-deep result register, so req_i.ready is high whenever that
// register is empty or is being drained in the same cycle. A write sends one
// 40-bit frame; a read sends two frames separated by a half period with all
// selects high. The half period register (0 acts as 1) sets the ticks per half bit
// and takes effect at once.
module stepper_driver_spi_datagram_master #(
  parameter int NUM_AXES = 5
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  sdsm_req_if.sink   req_i,
  sdsm_res_if.source res_o
);

  logic [7:0]     half_period_q;
  logic           step;
  logic           free;
  logic           out_valid;
  sdsm_pkg::req_t req;
  sdsm_pkg::res_t seq_res;
  sdsm_pkg::res_t out_res;

  // half period register, written from the configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= sdsm_pkg::HalfPeriodReset;
    end else if (cfg_we_i) begin
      half_period_q <= cfg_wdata_i;
    end
  end

  // request handshake
  assign req_i.ready = free;
  assign step        = req_i.valid && free;

  assign req.start_req        = req_i.start_req;
  assign req.mode             = req_i.mode;
  assign req.axis             = req_i.axis;
  assign req.register_address = req_i.register_address;
  assign req.write_data       = req_i.write_data;
  assign req.miso_level       = req_i.miso_level;

  // tick sequencer
  sdsm_seq #(
    .NUM_AXES (NUM_AXES)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .half_period_i (half_period_q),
    .step_i        (step),
    .req_i         (req),
    .res_o         (seq_res)
  );

  // result register decouples the two channels
  sdsm_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .res_i   (seq_res),
    .take_i  (res_o.ready),
    .free_o  (free),
    .valid_o (out_valid),
    .res_o   (out_res)
  );

  assign res_o.valid         = out_valid;
  assign res_o.sck_level     = out_res.sck_level;
  assign res_o.mosi_level    = out_res.mosi_level;
  assign res_o.chip_select_n = out_res.chip_select_n;
  assign res_o.busy_res      = out_res.busy_res;
  assign res_o.done_res      = out_res.done_res;
  assign res_o.status_byte   = out_res.status_byte;
  assign res_o.read_data     = out_res.read_data;

endmodule

// ===== hw/rtl/sdsm_seq.sv =====
// ----------------------------------------------------------------------------
// sdsm_seq
// bit sequencer: one tick per accepted request, pin levels from new state
// ----------------------------------------------------------------------------
module sdsm_seq #(
  parameter int NUM_AXES = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        half_period_i,
  input  logic              step_i,
  input  sdsm_pkg::req_t    req_i,
  output sdsm_pkg::res_t    res_o
);

  sdsm_pkg::seq_state_e state_q, state_d;
  logic [7:0]  tick_q, tick_d;
  logic [5:0]  bit_q, bit_d;
  logic [39:0] tx_q, tx_d;
  logic [39:0] rx_q, rx_d;
  logic [2:0]  axis_q, axis_d;
  logic        mode_q, mode_d;
  logic        second_q, second_d;

  logic [7:0]  half;
  logic        phase_end;
  logic        done;
  logic        framing;
  logic        bit_live;
  logic [5:0]  tx_sel;
  logic [7:0]  axis_oh;

  assign half      = (half_period_i == 8'd0) ? 8'd1 : half_period_i;
  assign phase_end = ({1'b0, tick_q} + 9'd1) >= {1'b0, half};

  always_comb begin
    state_d  = state_q;
    tick_d   = tick_q;
    bit_d    = bit_q;
    tx_d     = tx_q;
    rx_d     = rx_q;
    axis_d   = axis_q;
    mode_d   = mode_q;
    second_d = second_q;
    done     = 1'b0;
    unique case (state_q)
      sdsm_pkg::ST_IDLE: begin
        if (req_i.start_req && ({1'b0, req_i.axis} < 4'(NUM_AXES))) begin
          axis_d = req_i.axis;
          mode_d = req_i.mode;
          if (req_i.mode == sdsm_pkg::MODE_WRITE) begin
            tx_d = {sdsm_pkg::WriteFlag, req_i.register_address, req_i.write_data};
          end else begin
            tx_d = {1'b0, req_i.register_address, 32'd0};
          end
          rx_d     = '0;
          bit_d    = '0;
          tick_d   = '0;
          second_d = 1'b0;
          state_d  = sdsm_pkg::ST_LOW;
        end
      end
      sdsm_pkg::ST_LOW: begin
        if (phase_end) begin
          rx_d    = {rx_q[38:0], req_i.miso_level};
          tick_d  = '0;
          state_d = sdsm_pkg::ST_HIGH;
        end else begin
          tick_d = tick_q + 8'd1;
        end
      end
      sdsm_pkg::ST_HIGH: begin
        if (phase_end) begin
          tick_d = '0;
          bit_d  = bit_q + 6'd1;
          if ({26'd0, bit_d} < sdsm_pkg::FrameBits) begin
            state_d = sdsm_pkg::ST_LOW;
          end else if (mode_q == sdsm_pkg::MODE_READ && !second_q) begin
            second_d = 1'b1;
            state_d  = sdsm_pkg::ST_GAP;
          end else begin
            bit_d   = '0;
            state_d = sdsm_pkg::ST_IDLE;
            done    = 1'b1;
          end
        end else begin
          tick_d = tick_q + 8'd1;
        end
      end
      sdsm_pkg::ST_GAP: begin
        if (phase_end) begin
          tick_d  = '0;
          bit_d   = '0;
          rx_d    = '0;
          state_d = sdsm_pkg::ST_LOW;
        end else begin
          tick_d = tick_q + 8'd1;
        end
      end
      default: begin
        state_d = sdsm_pkg::ST_IDLE;
        tick_d  = '0;
        bit_d   = '0;
      end
    endcase
  end

  // pins follow the state after this tick
  assign framing  = (state_d == sdsm_pkg::ST_LOW) || (state_d == sdsm_pkg::ST_HIGH);
  assign bit_live = framing && ({26'd0, bit_d} < sdsm_pkg::FrameBits);
  assign tx_sel   = 6'd39 - bit_d;
  assign axis_oh  = 8'd1 << axis_d;

  always_comb begin
    res_o               = '0;
    res_o.sck_level     = (state_d != sdsm_pkg::ST_LOW);
    res_o.mosi_level    = bit_live ? tx_d[tx_sel] : 1'b0;
    res_o.chip_select_n = bit_live ? ~axis_oh[sdsm_pkg::CsBits-1:0] : '1;
    res_o.busy_res      = (state_d != sdsm_pkg::ST_IDLE);
    res_o.done_res      = done;
    res_o.status_byte   = done ? rx_d[39:32] : 8'd0;
    res_o.read_data     = done ? rx_d[31:0] : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sdsm_pkg::ST_IDLE;
      tick_q   <= '0;
      bit_q    <= '0;
      tx_q     <= '0;
      rx_q     <= '0;
      axis_q   <= '0;
      mode_q   <= 1'b0;
      second_q <= 1'b0;
    end else if (step_i) begin
      state_q  <= state_d;
      tick_q   <= tick_d;
      bit_q    <= bit_d;
      tx_q     <= tx_d;
      rx_q     <= rx_d;
      axis_q   <= axis_d;
      mode_q   <= mode_d;
      second_q <= second_d;
    end
  end

  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done_res |-> !res_o.busy_res && res_o.sck_level)
    else $error("completion while still busy");

  a_one_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(~res_o.chip_select_n))
    else $error("more than one chip select low");

  a_gap_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sdsm_pkg::ST_GAP) |-> (mode_q == sdsm_pkg::MODE_READ) && second_q)
    else $error("deselect gap outside the first read frame");

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({26'd0, bit_q} <= sdsm_pkg::FrameBits))
    else $error("bit index past end of frame");

endmodule

// ===== hw/rtl/sdsm_out_reg.sv =====
// ----------------------------------------------------------------------------
// sdsm_out_reg
// result register between the sequencer and the result channel
// ----------------------------------------------------------------------------
module sdsm_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  sdsm_pkg::res_t res_i,
  input  logic           take_i,
  output logic           free_o,
  output logic           valid_o,
  output sdsm_pkg::res_t res_o
);

  logic           valid_q, valid_d;
  sdsm_pkg::res_t res_q;

  // slot is free when empty or being drained this cycle
  assign free_o  = !valid_q || take_i;
  assign valid_d = load_i || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== bench/stepper_driver_spi_datagram_master_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stepper_driver_spi_datagram_master_tb
// drives the serial engine one tick per request and checks every pin result
// against a cycle-true predictor of the mode 3 datagram sequencer, across
// several half periods including zero, one and the widest setting
// ----------------------------------------------------------------------------
module stepper_driver_spi_datagram_master_tb;

  localparam int NumAxes = 5;
  // longest stretch with no handshake on either side before giving up
  localparam int WatchdogLimit = 5000;
  // random ticks per half period setting
  localparam int PhaseTicks = 20;
  // miso patterns for the directed transfers
  localparam int MisoZeros = 0;
  localparam int MisoOnes = 1;
  localparam int MisoRandom = 2;

  // --------------------------------------------------------------------------
  // predictor and result store
  // --------------------------------------------------------------------------
  class pin_scoreboard;
    logic [7:0]             half_period;
    sdsm_pkg::seq_state_e   seq;
    logic [7:0]             ticks;
    logic [5:0]             bit_idx;
    logic [39:0]            tx_frame;
    logic [39:0]            rx_frame;
    logic [2:0]             axis_q;
    sdsm_pkg::xfer_mode_e   mode_q;
    logic                   second_frame;
    sdsm_pkg::res_t         expected_pins[$];
    int unsigned            errors;

    function new();
      half_period = sdsm_pkg::HalfPeriodReset;
      seq = sdsm_pkg::ST_IDLE;
      ticks = '0;
      bit_idx = '0;
      tx_frame = '0;
      rx_frame = '0;
      axis_q = '0;
      mode_q = sdsm_pkg::MODE_READ;
      second_frame = 1'b0;
      errors = 0;
    endfunction

    function void set_half_period(logic [7:0] value);
      half_period = value;
    endfunction

    function bit is_idle();
      return seq == sdsm_pkg::ST_IDLE;
    endfunction

    function int pending();
      return expected_pins.size();
    endfunction

    // advance the sequencer by one tick and queue the pins it should show
    function void note_request(sdsm_pkg::req_t r);
      int             h;
      bit             phase_end;
      bit             done;
      sdsm_pkg::res_t pins;
      logic [7:0]     sel;
      h = (half_period == 8'd0) ? 1 : int'(half_period);
      phase_end = (int'(ticks) + 1 >= h);
      done = 1'b0;
      case (seq)
        sdsm_pkg::ST_IDLE: begin
          if (r.start_req && int'(r.axis) < NumAxes) begin
            axis_q = r.axis;
            mode_q = sdsm_pkg::xfer_mode_e'(r.mode);
            if (mode_q == sdsm_pkg::MODE_WRITE)
              tx_frame = {sdsm_pkg::WriteFlag, r.register_address, r.write_data};
            else
              tx_frame = {~sdsm_pkg::WriteFlag, r.register_address, 32'h0};
            rx_frame = '0;
            bit_idx = '0;
            ticks = '0;
            second_frame = 1'b0;
            seq = sdsm_pkg::ST_LOW;
          end
        end
        sdsm_pkg::ST_LOW: begin
          if (phase_end) begin
            // miso sampled as sck rises
            rx_frame = {rx_frame[38:0], r.miso_level};
            ticks = '0;
            seq = sdsm_pkg::ST_HIGH;
          end else ticks = ticks + 8'd1;
        end
        sdsm_pkg::ST_HIGH: begin
          if (phase_end) begin
            ticks = '0;
            bit_idx = bit_idx + 6'd1;
            if (bit_idx < sdsm_pkg::FrameBits) seq = sdsm_pkg::ST_LOW;
            else if (mode_q == sdsm_pkg::MODE_READ && !second_frame) begin
              second_frame = 1'b1;
              seq = sdsm_pkg::ST_GAP;
            end else begin
              bit_idx = '0;
              seq = sdsm_pkg::ST_IDLE;
              done = 1'b1;
            end
          end else ticks = ticks + 8'd1;
        end
        sdsm_pkg::ST_GAP: begin
          if (phase_end) begin
            ticks = '0;
            bit_idx = '0;
            rx_frame = '0;
            seq = sdsm_pkg::ST_LOW;
          end else ticks = ticks + 8'd1;
        end
        default: begin
          seq = sdsm_pkg::ST_IDLE;
          ticks = '0;
          bit_idx = '0;
        end
      endcase

      pins = '0;
      pins.sck_level = (seq != sdsm_pkg::ST_LOW);
      pins.chip_select_n = '1;
      if ((seq == sdsm_pkg::ST_LOW || seq == sdsm_pkg::ST_HIGH) &&
          bit_idx < sdsm_pkg::FrameBits) begin
        pins.mosi_level = tx_frame[6'd39 - bit_idx];
        sel = 8'd1 << axis_q;
        pins.chip_select_n = ~sel[4:0];
      end
      pins.busy_res = (seq != sdsm_pkg::ST_IDLE);
      pins.done_res = done;
      if (done) begin
        pins.status_byte = rx_frame[39:32];
        pins.read_data = rx_frame[31:0];
      end
      expected_pins.push_back(pins);
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_pins(sdsm_pkg::res_t act);
      sdsm_pkg::res_t exp_p;
      if (expected_pins.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, act);
        errors++;
        return;
      end
      exp_p = expected_pins.pop_front();
      check_field("sck_level", exp_p.sck_level, act.sck_level);
      check_field("mosi_level", exp_p.mosi_level, act.mosi_level);
      check_field("chip_select_n", exp_p.chip_select_n, act.chip_select_n);
      check_field("busy_res", exp_p.busy_res, act.busy_res);
      check_field("done_res", exp_p.done_res, act.done_res);
      check_field("status_byte", exp_p.status_byte, act.status_byte);
      check_field("read_data", exp_p.read_data, act.read_data);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, block
  // --------------------------------------------------------------------------
  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  bit         gaps_on = 1'b1;   // cleared for a stretch with no idling
  int unsigned quiet_cycles;

  pin_scoreboard sb = new();

  sdsm_req_if req_if ();
  sdsm_res_if res_if ();

  stepper_driver_spi_datagram_master #(
    .NUM_AXES(NumAxes)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side back-pressure, changed on the falling edge
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready <= !(gaps_on && $urandom_range(99) < 6);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: both handshakes sampled on the rising edge, plus the watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    sdsm_pkg::res_t act;
    sdsm_pkg::req_t r;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        act.sck_level = res_if.sck_level;
        act.mosi_level = res_if.mosi_level;
        act.chip_select_n = res_if.chip_select_n;
        act.busy_res = res_if.busy_res;
        act.done_res = res_if.done_res;
        act.status_byte = res_if.status_byte;
        act.read_data = res_if.read_data;
        sb.check_pins(act);
      end
      if (req_if.valid && req_if.ready) begin
        r.start_req = req_if.start_req;
        r.mode = req_if.mode;
        r.axis = req_if.axis;
        r.register_address = req_if.register_address;
        r.write_data = req_if.write_data;
        r.miso_level = req_if.miso_level;
        sb.note_request(r);
      end
      if ((res_if.valid && res_if.ready) || (req_if.valid && req_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog, no handshake for %0d cycles", $time, quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // drive tasks
  // --------------------------------------------------------------------------

  // one tick request, with random idle cycles ahead of it
  task automatic send_tick(input sdsm_pkg::req_t r);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < 6) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.start_req <= r.start_req;
    req_if.mode <= r.mode;
    req_if.axis <= r.axis;
    req_if.register_address <= r.register_address;
    req_if.write_data <= r.write_data;
    req_if.miso_level <= r.miso_level;
    do @(posedge clk_i); while (!req_if.ready);
    // let the monitor note the accepted tick before the predictor is queried
    #1;
  endtask

  // random content; starts are likelier while the sequencer is idle and
  // about one in ten names an axis that does not exist
  function automatic sdsm_pkg::req_t random_request(bit idle_now);
    sdsm_pkg::req_t r;
    r.start_req = ($urandom_range(99) < (idle_now ? 70 : 25));
    r.mode = 1'($urandom_range(1));
    r.axis = ($urandom_range(99) < 10) ? 3'($urandom_range(7, NumAxes))
                                        : 3'($urandom_range(NumAxes - 1));
    r.register_address = 7'($urandom_range(127));
    r.write_data = $urandom;
    r.miso_level = 1'($urandom_range(1));
    return r;
  endfunction

  // ticks until the sequencer is idle or the limit runs out
  task automatic busy_ticks(input int limit, input int miso_sel, input bit noise);
    sdsm_pkg::req_t r;
    int             n;
    n = 0;
    while (!sb.is_idle() && n < limit) begin
      r = random_request(1'b0);
      if (!noise) r.start_req = 1'b0;
      if (miso_sel != MisoRandom) r.miso_level = (miso_sel == MisoOnes);
      send_tick(r);
      n++;
    end
  endtask

  task automatic start_xfer(input sdsm_pkg::xfer_mode_e m, input logic [2:0] ax,
                            input logic [6:0] addr, input logic [31:0] data);
    sdsm_pkg::req_t r;
    r.start_req = 1'b1;
    r.mode = m;
    r.axis = ax;
    r.register_address = addr;
    r.write_data = data;
    r.miso_level = 1'($urandom_range(1));
    send_tick(r);
  endtask

  task automatic transfer(input sdsm_pkg::xfer_mode_e m, input logic [2:0] ax,
                          input logic [6:0] addr, input logic [31:0] data,
                          input int miso_sel, input bit noise);
    start_xfer(m, ax, addr, data);
    busy_ticks(1 << 20, miso_sel, noise);
  endtask

  // hold off requests until every result is in, then write the register
  task automatic set_half_period(input logic [7:0] value);
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    sb.set_half_period(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    int             hp_list[8];
    sdsm_pkg::req_t r;
    hp_list = '{1, 0, 3, 1, 2, 1, 4, 1};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.start_req = 1'b0;
    req_if.mode = 1'b0;
    req_if.axis = '0;
    req_if.register_address = '0;
    req_if.write_data = '0;
    req_if.miso_level = 1'b0;
    quiet_cycles = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // write under the reset half period, switched to zero mid-frame
    start_xfer(sdsm_pkg::MODE_WRITE, 3'd0, 7'h00, 32'h0000_0000);
    busy_ticks(25, MisoOnes, 1'b0);
    set_half_period(8'd0);
    busy_ticks(1 << 20, MisoOnes, 1'b0);

    // all-ones write on the top axis with start requests landing while busy
    set_half_period(8'd1);
    transfer(sdsm_pkg::MODE_WRITE, 3'(NumAxes - 1), 7'h7f, 32'hffff_ffff, MisoZeros,
             1'b1);

    // starts naming axes that do not exist are dropped
    r = random_request(1'b1);
    r.start_req = 1'b1;
    for (int a = NumAxes; a < 8; a++) begin
      r.axis = 3'(a);
      r.mode = a[0];
      send_tick(r);
    end

    // read ignores its data field
    transfer(sdsm_pkg::MODE_READ, 3'd2, 7'h7f, 32'hffff_ffff, MisoOnes, 1'b1);

    // widest half period for a while, then narrowed mid-frame
    set_half_period(8'd255);
    start_xfer(sdsm_pkg::MODE_READ, 3'd3, 7'h11, 32'h0);
    busy_ticks(60, MisoRandom, 1'b1);
    set_half_period(8'd1);
    busy_ticks(1 << 20, MisoRandom, 1'b1);

    // random phases, one of them a long stretch with no idling on either side
    foreach (hp_list[p]) begin
      set_half_period(8'(hp_list[p]));
      gaps_on = (p != 3);
      repeat ((p == 3) ? 5 * PhaseTicks : PhaseTicks)
        send_tick(random_request(sb.is_idle()));
    end
    gaps_on = 1'b1;
    busy_ticks(1 << 20, MisoRandom, 1'b1);

    // drain, then keep watching for any stray result before the verdict
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
